FILE: hdl/sne_pkg.sv
// ----------------------------------------------------------------------------
// sne_pkg
// Types, register indexes and saturation helpers for the Euler-step neuron.
// ----------------------------------------------------------------------------
package sne_pkg;

    localparam int CfgIdxW = 4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_VR  = 4'd0,
        REG_VT  = 4'd1,
        REG_A   = 4'd2,
        REG_B   = 4'd3,
        REG_C   = 4'd4,
        REG_D   = 4'd5,
        REG_K   = 4'd6,
        REG_CAP = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] input_current;
        logic        [31:0] step_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] membrane_potential;
        logic               spiked;
        logic        [31:0] spike_count;
        logic        [31:0] last_spike_time;
    } t_out_item;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        logic signed [31:0] y;
        if (x > 34'sh7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -34'sh8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

FILE: hdl/sne_stream_if.sv
// ----------------------------------------------------------------------------
// sne_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface sne_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

FILE: hdl/sne_div.sv
// ----------------------------------------------------------------------------
// sne_div
// Restoring divider, one quotient bit per cycle: (num * 2^FRAC_BITS) / cap,
// truncated toward zero and saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module sne_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_num,
    input  logic        [30:0] i_cap,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int DW = 33 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate            r_state;
    logic [DW-1:0]      r_dvd;
    logic [30:0]        r_rem;
    logic [30:0]        r_cap;
    logic [CW-1:0]      r_cnt;
    logic               r_neg;
    logic               r_done;
    logic signed [31:0] r_quot;

    logic [32:0] num_mag;
    logic [31:0] rem_sh;
    logic [32:0] diff;
    logic        q_big_neg;
    logic        q_big_pos;

    always_comb begin
        num_mag   = i_num[33] ? 33'(-i_num) : 33'(i_num);
        rem_sh    = {r_rem, r_dvd[DW-1]};
        diff      = {1'b0, rem_sh} - {2'b00, r_cap};
        q_big_neg = (|r_dvd[DW-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));
        q_big_pos = |r_dvd[DW-1:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {num_mag, {FRAC_BITS{1'b0}}};
                        r_neg   <= i_num[33];
                        r_cap   <= (i_cap == '0) ? 31'd1 : i_cap;
                        r_rem   <= '0;
                        r_cnt   <= CW'(DW);
                        r_done  <= 1'b0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_dvd <= {r_dvd[DW-2:0], ~diff[32]};
                    r_rem <= diff[32] ? rem_sh[30:0] : diff[30:0];
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    if (r_neg) begin
                        r_quot <= q_big_neg ? 32'sh8000_0000 : 32'(-r_dvd[31:0]);
                    end else begin
                        r_quot <= q_big_pos ? 32'sh7FFF_FFFF : 32'(r_dvd[31:0]);
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/spiking_neuron_euler_step.sv
// ----------------------------------------------------------------------------
// spiking_neuron_euler_step
// Two-variable spiking neuron advanced by one forward-Euler step per item,
// signed fixed point with FRAC_BITS fraction bits.
//
//   channel    | dir | handshake      | payload
//   -----------+-----+----------------+-----------------------------------
//   i_step     | in  | valid / ready  | input_current, step_time
//   o_result   | out | valid / ready  | membrane_potential, spiked,
//              |     |                | spike_count, last_spike_time
//   i_cfg_*    | in  | write enable   | register index, 32-bit data
//
// The sequencer takes one item at a time, paced by the divider, which yields
// one quotient bit per cycle; the next input can transfer only once the current
// item has been written to the output register. The four products share one
// 32x32 multiplier. i_step.ready is high only while the sequencer is idle. A
// finished result waits in the output register; the next item is taken meanwhile
// and holds in its last step until that register is free.
// Synchronous active-low reset restores register defaults and neuron state.
// ----------------------------------------------------------------------------
module spiking_neuron_euler_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sne_stream_if.sink                     i_step,
    sne_stream_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [sne_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);
    localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
    localparam logic [31:0] RST_VR  = 32'(-60 * ONE_Q);
    localparam logic [31:0] RST_VT  = 32'(-40 * ONE_Q);
    localparam logic [31:0] RST_A   = 32'((3 * ONE_Q) / 100);
    localparam logic [31:0] RST_B   = 32'(-2 * ONE_Q);
    localparam logic [31:0] RST_C   = 32'(-50 * ONE_Q);
    localparam logic [31:0] RST_D   = 32'(100 * ONE_Q);
    localparam logic [31:0] RST_K   = 32'((7 * ONE_Q) / 10);
    localparam logic [30:0] RST_CAP = 31'(100 * ONE_Q);

    typedef enum logic [3:0] {
        S_IDLE, S_DV, S_DT, S_MSQ, S_SQ, S_MQ, S_QUAD, S_MBD,
        S_BD, S_E, S_MU, S_UN, S_WDIV, S_FIN
    } t_state;

    // configuration
    logic signed [31:0] r_vr, r_vt, r_a, r_b, r_c, r_d, r_k;
    logic        [30:0] r_cap;

    // neuron state
    logic signed [31:0] r_v, r_u;
    logic        [31:0] r_cnt, r_stamp;

    // working registers
    t_state             r_state;
    logic signed [31:0] r_cur;
    logic        [31:0] r_step_time;
    logic signed [31:0] r_t1, r_t2, r_un, r_vn;
    logic signed [33:0] r_num;
    logic signed [63:0] r_prod;
    logic               r_div_start;
    logic               r_out_valid;
    sne_pkg::t_out_item r_out;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [31:0] mul_sat;
    logic signed [31:0] add_a, add_b;
    logic               add_sub;
    logic signed [31:0] add_sat;
    logic signed [31:0] un_jump;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               spike;
    logic               out_free;

    sne_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_cap   (r_cap),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MSQ:   begin mul_a = r_t1; mul_b = r_t2; end
            S_MQ:    begin mul_a = r_k;  mul_b = r_t2; end
            S_MBD:   begin mul_a = r_b;  mul_b = r_t1; end
            S_MU:    begin mul_a = r_a;  mul_b = r_t1; end
            default: begin mul_a = r_t1; mul_b = r_t2; end
        endcase
        mul_p   = 64'(mul_a) * 64'(mul_b);
        mul_sat = sne_pkg::sat64(r_prod >>> FRAC_BITS);
    end

    // shared saturating adder operand select
    always_comb begin
        add_sub = 1'b0;
        case (r_state)
            S_DV:    begin add_a = r_v;  add_b = r_vr;     add_sub = 1'b1; end
            S_DT:    begin add_a = r_v;  add_b = r_vt;     add_sub = 1'b1; end
            S_E:     begin add_a = r_t1; add_b = r_u;      add_sub = 1'b1; end
            S_UN:    begin add_a = r_u;  add_b = mul_sat;                  end
            S_WDIV:  begin add_a = r_v;  add_b = div_quot;                 end
            default: begin add_a = r_un; add_b = r_d;                      end
        endcase
        add_sat = sne_pkg::sat34(add_sub ? (34'(add_a) - 34'(add_b))
                                         : (34'(add_a) + 34'(add_b)));
        un_jump  = add_sat;
        spike    = r_vn > r_vt;
        out_free = !r_out_valid || o_result.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr  <= RST_VR;
            r_vt  <= RST_VT;
            r_a   <= RST_A;
            r_b   <= RST_B;
            r_c   <= RST_C;
            r_d   <= RST_D;
            r_k   <= RST_K;
            r_cap <= RST_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sne_pkg::REG_VR:  r_vr  <= i_cfg_data;
                sne_pkg::REG_VT:  r_vt  <= i_cfg_data;
                sne_pkg::REG_A:   r_a   <= i_cfg_data;
                sne_pkg::REG_B:   r_b   <= i_cfg_data;
                sne_pkg::REG_C:   r_c   <= i_cfg_data;
                sne_pkg::REG_D:   r_d   <= i_cfg_data;
                sne_pkg::REG_K:   r_k   <= i_cfg_data;
                sne_pkg::REG_CAP: r_cap <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= RST_VR;
            r_u         <= '0;
            r_cnt       <= '0;
            r_stamp     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_QUAD);
            if (r_out_valid && o_result.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_step.valid) begin
                        r_cur       <= i_step.payload.input_current;
                        r_step_time <= i_step.payload.step_time;
                        r_state     <= S_DV;
                    end
                end
                S_DV: begin
                    r_t1    <= add_sat;
                    r_state <= S_DT;
                end
                S_DT: begin
                    r_t2    <= add_sat;
                    r_state <= S_MSQ;
                end
                S_MSQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_t2    <= mul_sat;
                    r_state <= S_MQ;
                end
                S_MQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_QUAD;
                end
                S_QUAD: begin
                    r_num       <= 34'(mul_sat) - 34'(r_u) + 34'(r_cur);
                    r_state     <= S_MBD;
                end
                S_MBD: begin
                    r_prod  <= mul_p;
                    r_state <= S_BD;
                end
                S_BD: begin
                    r_t1    <= mul_sat;
                    r_state <= S_E;
                end
                S_E: begin
                    r_t1    <= add_sat;
                    r_state <= S_MU;
                end
                S_MU: begin
                    r_prod  <= mul_p;
                    r_state <= S_UN;
                end
                S_UN: begin
                    r_un    <= add_sat;
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_vn    <= add_sat;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out.spiked <= spike;
                        if (spike) begin
                            r_v   <= r_c;
                            r_u   <= un_jump;
                            r_out.membrane_potential <= r_c;
                            r_out.spike_count <= (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
                            r_out.last_spike_time <= r_step_time;
                            if (r_cnt != '1) begin
                                r_cnt <= r_cnt + 32'd1;
                            end
                            r_stamp <= r_step_time;
                        end else begin
                            r_v   <= r_vn;
                            r_u   <= r_un;
                            r_out.membrane_potential <= r_vn;
                            r_out.spike_count        <= r_cnt;
                            r_out.last_spike_time    <= r_stamp;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_step.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

FILE: hdl/sne_checker.sv
// ----------------------------------------------------------------------------
// sne_checker
// Port-level checks on the neuron step block, bound to its top level.
// ----------------------------------------------------------------------------
module sne_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_step_valid,
    input logic               i_step_ready,
    input logic               i_result_valid,
    input logic               i_result_ready,
    input sne_pkg::t_out_item i_result_payload
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_result_valid)
        else $error("result valid after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step_valid && i_step_ready |=> !i_step_ready)
        else $error("input ready straight after a transfer");

    a_spike_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && i_result_payload.spiked
            |-> i_result_payload.spike_count != 32'd0)
        else $error("spike reported with zero count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && !i_result_ready |=> i_result_valid && $stable(i_result_payload))
        else $error("stalled result changed or dropped");

endmodule

bind spiking_neuron_euler_step sne_checker u_sne_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_step_valid     (i_step.valid),
    .i_step_ready     (i_step.ready),
    .i_result_valid   (o_result.valid),
    .i_result_ready   (o_result.ready),
    .i_result_payload (o_result.payload)
);
